/* sv/hps_pkg.sv */
// Package for the haptic pulse scheduler: field widths, operation, priority and
// register index codes, register reset values. No dependencies.
`default_nettype none

package hps_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned STAT_W  = 32;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned PRIO_W  = 2;
   localparam int unsigned CSR_A_W = 2;
   localparam int unsigned CSR_D_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_TICK        = 3'd0,
      OP_PULSE       = 3'd1,
      OP_SET_PERIOD  = 3'd2,
      OP_STOP        = 3'd3,
      OP_CLEAR_STATS = 3'd4
   } op_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_GUARD      = 2'd0,
      CSR_MIN_GAP    = 2'd1,
      CSR_GEIGER_LEN = 2'd2
   } csr_index_type;

   localparam logic [PRIO_W-1:0] PRIO_GEIGER = 2'd1;
   localparam logic [PRIO_W-1:0] PRIO_EVENT  = 2'd2;

   localparam logic [LEN_W-1:0] GUARD_RESET      = 16'd30;
   localparam logic [LEN_W-1:0] MIN_GAP_RESET    = 16'd60;
   localparam logic [LEN_W-1:0] GEIGER_LEN_RESET = 16'd20;

endpackage

`default_nettype wire

/* sv/hps_if.sv */
// Valid/ready channel interfaces of the haptic pulse scheduler: request,
// response and register write. Depends on hps_pkg.
`default_nettype none

interface hps_req_if;
   logic                        valid;
   logic                        ready;
   logic [hps_pkg::OP_W-1:0]    op;
   logic [hps_pkg::TIME_W-1:0]  now_ms;
   logic [hps_pkg::LEN_W-1:0]   pulse_len_ms;
   logic [hps_pkg::PRIO_W-1:0]  priority_req;
   logic [hps_pkg::LEN_W-1:0]   interval_ms;

   modport source (output valid, op, now_ms, pulse_len_ms, priority_req, interval_ms,
                   input ready);
   modport sink   (input valid, op, now_ms, pulse_len_ms, priority_req, interval_ms,
                   output ready);
endinterface

interface hps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic                        fire;
   logic [hps_pkg::LEN_W-1:0]   fire_len_ms;
   logic [hps_pkg::TIME_W-1:0]  last_start_ms;
   logic [hps_pkg::STAT_W-1:0]  fired_count;
   logic [hps_pkg::STAT_W-1:0]  dropped_count;
   logic [hps_pkg::STAT_W-1:0]  queued_count;
   logic [hps_pkg::STAT_W-1:0]  geiger_count;
   logic [hps_pkg::STAT_W-1:0]  smallest_gap_ms;
   logic [hps_pkg::STAT_W-1:0]  longest_wait_ms;

   modport source (output valid, accepted, fire, fire_len_ms, last_start_ms, fired_count,
                   dropped_count, queued_count, geiger_count, smallest_gap_ms,
                   longest_wait_ms,
                   input ready);
   modport sink   (input valid, accepted, fire, fire_len_ms, last_start_ms, fired_count,
                   dropped_count, queued_count, geiger_count, smallest_gap_ms,
                   longest_wait_ms,
                   output ready);
endinterface

interface hps_csr_if;
   logic                         valid;
   logic                         ready;
   logic [hps_pkg::CSR_A_W-1:0]  index;
   logic [hps_pkg::CSR_D_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/haptic_pulse_scheduler.sv */
// Haptic pulse scheduler top level: input register, scheduling logic, response register.
// Depends on hps_pkg and the channel interfaces in hps_if.sv.
`default_nettype none

// One request word is taken per cycle unless a stalled response word blocks the input
// register, and every request gives exactly one response word. A word passes from the
// input register to the response register, which holds it until the sink is ready;
// the scheduler state is updated in the single pass between those registers.
// Register writes are taken in any cycle and must only be issued while the block
// holds no request whose response is still outstanding.
module haptic_pulse_scheduler (
   input  wire logic   clock,
   input  wire logic   reset,
   hps_req_if.sink     req_ch,
   hps_rsp_if.source   rsp_ch,
   hps_csr_if.sink     csr_ch
);
   import hps_pkg::*;

   // configuration
   logic [LEN_W-1:0]  guard_ff, min_gap_ff, geiger_len_ff;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]   s1_op_ff;
   logic [TIME_W-1:0] s1_now_ff;
   logic [LEN_W-1:0]  s1_len_ff;
   logic [PRIO_W-1:0] s1_prio_ff;
   logic [LEN_W-1:0]  s1_period_ff;

   // scheduler state
   logic [TIME_W-1:0] last_start_ff, last_start_in;
   logic [LEN_W-1:0]  last_len_ff, last_len_in;
   logic [LEN_W-1:0]  tick_period_ff, tick_period_in;
   logic [TIME_W-1:0] due_ff, due_in;
   logic              due_valid_ff, due_valid_in;
   logic [LEN_W-1:0]  wait_len_ff, wait_len_in;
   logic [TIME_W-1:0] wait_since_ff, wait_since_in;
   logic [STAT_W-1:0] fired_ff, fired_in;
   logic [STAT_W-1:0] dropped_ff, dropped_in;
   logic [STAT_W-1:0] queued_ff, queued_in;
   logic [STAT_W-1:0] geiger_ff, geiger_in;
   logic [STAT_W-1:0] small_gap_ff, small_gap_in;
   logic [STAT_W-1:0] long_wait_ff, long_wait_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, accepted_in;
   logic              rsp_fire_ff, fire_in;
   logic [LEN_W-1:0]  rsp_fire_len_ff, fire_len_in;

   // handshake
   logic req_hs, out_free, step;

   assign req_hs       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign step         = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_hs) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // scheduling datapath
   logic [TIME_W-1:0] elapsed, waited, behind, due_adv, past_adv;
   logic [TIME_W-1:0] now_plus_tick, now_plus_new;
   logic [LEN_W:0]    len_guard;
   logic              busy, far_behind, start_en, is_event;
   logic [LEN_W-1:0]  start_len;

   always_comb begin
      elapsed       = s1_now_ff - last_start_ff;
      waited        = s1_now_ff - wait_since_ff;
      len_guard     = {1'b0, last_len_ff} + {1'b0, guard_ff};
      busy          = (last_len_ff != '0) &&
                      ((elapsed < TIME_W'(len_guard)) || (elapsed < TIME_W'(min_gap_ff)));
      behind        = s1_now_ff - due_ff;
      due_adv       = due_ff + TIME_W'(tick_period_ff);
      past_adv      = s1_now_ff - due_adv;
      far_behind    = !past_adv[TIME_W-1] && (past_adv > TIME_W'(tick_period_ff));
      now_plus_tick = s1_now_ff + TIME_W'(tick_period_ff);
      now_plus_new  = s1_now_ff + TIME_W'(s1_period_ff);
      is_event      = s1_prio_ff >= PRIO_EVENT;
   end

   always_comb begin
      tick_period_in = tick_period_ff;
      due_in         = due_ff;
      due_valid_in   = due_valid_ff;
      wait_len_in    = wait_len_ff;
      wait_since_in  = wait_since_ff;
      dropped_in     = dropped_ff;
      queued_in      = queued_ff;
      geiger_in      = geiger_ff;
      long_wait_in   = long_wait_ff;
      accepted_in    = 1'b0;
      start_en       = 1'b0;
      start_len      = '0;
      unique case (s1_op_ff)
         OP_TICK: begin
            if ((wait_len_ff != '0) && !busy) begin
               if (waited > long_wait_ff) begin
                  long_wait_in = waited;
               end
               start_en    = 1'b1;
               start_len   = wait_len_ff;
               wait_len_in = '0;
            end else if (tick_period_ff != '0) begin
               if (!due_valid_ff) begin
                  due_in       = now_plus_tick;
                  due_valid_in = 1'b1;
               end else if (!behind[TIME_W-1]) begin
                  due_in = far_behind ? now_plus_tick : due_adv;
                  if (busy) begin
                     dropped_in = dropped_ff + 1'b1;
                  end else begin
                     start_en  = 1'b1;
                     start_len = geiger_len_ff;
                     geiger_in = geiger_ff + 1'b1;
                  end
               end
            end
         end
         OP_PULSE: begin
            if (!busy) begin
               start_en    = 1'b1;
               start_len   = s1_len_ff;
               accepted_in = 1'b1;
               if (s1_prio_ff == PRIO_GEIGER) begin
                  geiger_in = geiger_ff + 1'b1;
               end
            end else if (is_event) begin
               wait_len_in   = s1_len_ff;
               wait_since_in = s1_now_ff;
               queued_in     = queued_ff + 1'b1;
               accepted_in   = 1'b1;
            end else begin
               dropped_in = dropped_ff + 1'b1;
            end
         end
         OP_SET_PERIOD: begin
            if (s1_period_ff != tick_period_ff) begin
               tick_period_in = s1_period_ff;
               if (s1_period_ff == '0) begin
                  due_in       = '0;
                  due_valid_in = 1'b0;
               end else if (!due_valid_ff || (now_plus_new < due_ff)) begin
                  due_in       = now_plus_new;
                  due_valid_in = 1'b1;
               end
            end
         end
         OP_STOP: begin
            tick_period_in = '0;
            due_in         = '0;
            due_valid_in   = 1'b0;
            wait_len_in    = '0;
         end
         OP_CLEAR_STATS: begin
            dropped_in   = '0;
            queued_in    = '0;
            geiger_in    = '0;
            long_wait_in = '0;
         end
         default: begin
         end
      endcase
   end

   // pulse start bookkeeping
   always_comb begin
      last_start_in = last_start_ff;
      last_len_in   = last_len_ff;
      fired_in      = fired_ff;
      small_gap_in  = small_gap_ff;
      fire_in       = start_en;
      fire_len_in   = start_len;
      if (s1_op_ff == OP_CLEAR_STATS) begin
         fired_in     = '0;
         small_gap_in = '0;
      end else if (start_en) begin
         if ((fired_ff != '0) && ((small_gap_ff == '0) || (elapsed < small_gap_ff))) begin
            small_gap_in = elapsed;
         end
         last_start_in = s1_now_ff;
         last_len_in   = start_len;
         fired_in      = fired_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff      <= GUARD_RESET;
         min_gap_ff    <= MIN_GAP_RESET;
         geiger_len_ff <= GEIGER_LEN_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_GUARD:      guard_ff      <= csr_ch.data;
            CSR_MIN_GAP:    min_gap_ff    <= csr_ch.data;
            CSR_GEIGER_LEN: geiger_len_ff <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_hs) begin
         s1_op_ff     <= req_ch.op;
         s1_now_ff    <= req_ch.now_ms;
         s1_len_ff    <= req_ch.pulse_len_ms;
         s1_prio_ff   <= req_ch.priority_req;
         s1_period_ff <= req_ch.interval_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_start_ff  <= '0;
         last_len_ff    <= '0;
         tick_period_ff <= '0;
         due_ff         <= '0;
         due_valid_ff   <= 1'b0;
         wait_len_ff    <= '0;
         wait_since_ff  <= '0;
         fired_ff       <= '0;
         dropped_ff     <= '0;
         queued_ff      <= '0;
         geiger_ff      <= '0;
         small_gap_ff   <= '0;
         long_wait_ff   <= '0;
      end else if (step) begin
         last_start_ff  <= last_start_in;
         last_len_ff    <= last_len_in;
         tick_period_ff <= tick_period_in;
         due_ff         <= due_in;
         due_valid_ff   <= due_valid_in;
         wait_len_ff    <= wait_len_in;
         wait_since_ff  <= wait_since_in;
         fired_ff       <= fired_in;
         dropped_ff     <= dropped_in;
         queued_ff      <= queued_in;
         geiger_ff      <= geiger_in;
         small_gap_ff   <= small_gap_in;
         long_wait_ff   <= long_wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_accepted_ff <= accepted_in;
         rsp_fire_ff     <= fire_in;
         rsp_fire_len_ff <= fire_len_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.accepted        = rsp_accepted_ff;
   assign rsp_ch.fire            = rsp_fire_ff;
   assign rsp_ch.fire_len_ms     = rsp_fire_len_ff;
   assign rsp_ch.last_start_ms   = last_start_ff;
   assign rsp_ch.fired_count     = fired_ff;
   assign rsp_ch.dropped_count   = dropped_ff;
   assign rsp_ch.queued_count    = queued_ff;
   assign rsp_ch.geiger_count    = geiger_ff;
   assign rsp_ch.smallest_gap_ms = small_gap_ff;
   assign rsp_ch.longest_wait_ms = long_wait_ff;

endmodule

`default_nettype wire

/* sv/hps_checker.sv */
// Port-level checker for the haptic pulse scheduler and its bind.
// Depends on hps_pkg; attaches to haptic_pulse_scheduler.
`default_nettype none

module hps_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_fire,
   input wire logic [hps_pkg::LEN_W-1:0]  rsp_fire_len_ms,
   input wire logic [hps_pkg::STAT_W-1:0] rsp_fired_count
);
   import hps_pkg::*;

   logic       req_hs, rsp_hs;
   logic [1:0] pending_ff, pending_in;

   assign req_hs = req_valid && req_ready;
   assign rsp_hs = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_hs} - {1'b0, rsp_hs};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no response word left over from before reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_fire) && $stable(rsp_fire_len_ms) &&
         $stable(rsp_fired_count))
      else $error("stalled response word changed");

   // every response word belongs to an accepted request
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   // at most two words in flight: input register and response register
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more words outstanding than the block can hold");

endmodule

bind haptic_pulse_scheduler hps_checker u_hps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_fire        (rsp_ch.fire),
   .rsp_fire_len_ms (rsp_ch.fire_len_ms),
   .rsp_fired_count (rsp_ch.fired_count)
);

`default_nettype wire
